[src/tcq_pkg.sv]
// Shared types and codes for the two-class queue with promotion.
package tcq_pkg;

  localparam int ID_WIDTH     = 14;
  localparam int CMD_WIDTH    = 2;
  localparam int STATUS_WIDTH = 2;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_PROMOTE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_BUBBLE,
    S_REPORT
  } state_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic load;   // write the new entry into the cell at sel
    logic shift;  // every cell takes its right neighbour (head leaves)
    logic swap;   // exchange the cells at sel and sel-1
  } cell_ctl_t;

endpackage

[src/two_class_queue_with_promotion_unit.sv]
// Top level: two-class queue with promotion (chain of entry cells plus sequencer).
// Push, pop and unused commands pass through the execute state to the result register;
//   promote scans from the head for the first match and then swaps it forward, one slot
//   per cycle, before the report state. A new command is taken only in the idle state,
//   so no new item is accepted until the last result has been registered. Reset: clears
//   the entry count, urgent count, sequencer and result valid; entry contents and the
//   occupancy output are not cleared.
module two_class_queue_with_promotion_unit #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tcq_pkg::CMD_WIDTH-1:0]    cmd,
  input  logic [tcq_pkg::ID_WIDTH-1:0]     flight_id,
  input  logic [PAYLOAD_WIDTH-1:0]         payload,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tcq_pkg::STATUS_WIDTH-1:0] status,
  output logic                             popped_valid,
  output logic [tcq_pkg::ID_WIDTH-1:0]     popped_id,
  output logic [PAYLOAD_WIDTH-1:0]         popped_payload,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy
);
  import tcq_pkg::*;

  // Count width holds the full depth; slot index width addresses one cell.
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);

  cell_ctl_t                ctl;
  logic [CW-1:0]            sel;
  logic [ID_WIDTH-1:0]      load_id;
  logic [PAYLOAD_WIDTH-1:0] load_payload;
  logic [QUEUE_DEPTH-1:0]   cell_match;
  logic [ID_WIDTH-1:0]      cell_id      [QUEUE_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] cell_payload [QUEUE_DEPTH];

  // The sequencer owns the handshakes, the occupancy and urgent-prefix counts,
  // the scan pointer for promote and the result register that parts the two sides.
  tcq_ctrl #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH),
    .CW           (CW),
    .IW           (IW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .flight_id     (flight_id),
    .payload       (payload),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .popped_valid  (popped_valid),
    .popped_id     (popped_id),
    .popped_payload(popped_payload),
    .occupancy     (occupancy),
    .cell_match    (cell_match),
    .head_id       (cell_id[0]),
    .head_payload  (cell_payload[0]),
    .ctl           (ctl),
    .sel           (sel),
    .load_id       (load_id),
    .load_payload  (load_payload)
  );

  // Row of slots, head at index 0. A pop shifts every slot one place towards
  // the head; a promote walks the found entry forward by swapping it with its
  // left neighbour once per cycle until it sits just behind the urgent prefix.
  // Each slot compares its own identifier with the incoming one so the match
  // vector is captured at the input transfer.
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic [ID_WIDTH-1:0]      prev_id, next_id;
    logic [PAYLOAD_WIDTH-1:0] prev_payload, next_payload;

    if (k == 0) begin : g_first
      assign prev_id      = '0;
      assign prev_payload = '0;
    end else begin : g_mid_prev
      assign prev_id      = cell_id[k-1];
      assign prev_payload = cell_payload[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign next_id      = '0;
      assign next_payload = '0;
    end else begin : g_mid_next
      assign next_id      = cell_id[k+1];
      assign next_payload = cell_payload[k+1];
    end

    tcq_cell #(
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH),
      .CW           (CW),
      .INDEX        (k)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .sel         (sel),
      .load_id     (load_id),
      .load_payload(load_payload),
      .prev_id     (prev_id),
      .prev_payload(prev_payload),
      .next_id     (next_id),
      .next_payload(next_payload),
      .key_id      (flight_id),
      .id          (cell_id[k]),
      .payload     (cell_payload[k]),
      .match       (cell_match[k])
    );
  end

endmodule

[src/tcq_cell.sv]
// One queue slot: holds an entry and exchanges it with its neighbours.
module tcq_cell #(
  parameter int PAYLOAD_WIDTH = 32,
  parameter int CW            = 5,
  parameter int INDEX         = 0
) (
  input  logic                          clk,
  input  tcq_pkg::cell_ctl_t            ctl,
  input  logic [CW-1:0]                 sel,
  input  logic [tcq_pkg::ID_WIDTH-1:0]  load_id,
  input  logic [PAYLOAD_WIDTH-1:0]      load_payload,
  input  logic [tcq_pkg::ID_WIDTH-1:0]  prev_id,
  input  logic [PAYLOAD_WIDTH-1:0]      prev_payload,
  input  logic [tcq_pkg::ID_WIDTH-1:0]  next_id,
  input  logic [PAYLOAD_WIDTH-1:0]      next_payload,
  input  logic [tcq_pkg::ID_WIDTH-1:0]  key_id,
  output logic [tcq_pkg::ID_WIDTH-1:0]  id,
  output logic [PAYLOAD_WIDTH-1:0]      payload,
  output logic                          match
);
  import tcq_pkg::*;

  localparam logic [CW-1:0] MY_POS   = CW'(INDEX);
  localparam logic [CW-1:0] NEXT_POS = CW'(INDEX + 1);

  always_ff @(posedge clk) begin
    priority if (ctl.shift) begin
      id      <= next_id;
      payload <= next_payload;
    end else if (ctl.load && sel == MY_POS) begin
      id      <= load_id;
      payload <= load_payload;
    end else if (ctl.swap && sel == MY_POS) begin
      id      <= prev_id;
      payload <= prev_payload;
    end else if (ctl.swap && sel == NEXT_POS) begin
      id      <= next_id;
      payload <= next_payload;
    end else begin
      id      <= id;
      payload <= payload;
    end
  end

  assign match = (id == key_id);

endmodule

[src/tcq_ctrl.sv]
// Sequencer: handshakes, counters, search and move steps, result register.
module tcq_ctrl #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PAYLOAD_WIDTH = 32,
  parameter int CW            = 5,
  parameter int IW            = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tcq_pkg::CMD_WIDTH-1:0]   cmd,
  input  logic [tcq_pkg::ID_WIDTH-1:0]    flight_id,
  input  logic [PAYLOAD_WIDTH-1:0]        payload,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tcq_pkg::STATUS_WIDTH-1:0] status,
  output logic                            popped_valid,
  output logic [tcq_pkg::ID_WIDTH-1:0]    popped_id,
  output logic [PAYLOAD_WIDTH-1:0]        popped_payload,
  output logic [CW-1:0]                   occupancy,
  input  logic [QUEUE_DEPTH-1:0]          cell_match,
  input  logic [tcq_pkg::ID_WIDTH-1:0]    head_id,
  input  logic [PAYLOAD_WIDTH-1:0]        head_payload,
  output tcq_pkg::cell_ctl_t              ctl,
  output logic [CW-1:0]                   sel,
  output logic [tcq_pkg::ID_WIDTH-1:0]    load_id,
  output logic [PAYLOAD_WIDTH-1:0]        load_payload
);
  import tcq_pkg::*;

  localparam logic [CW-1:0] DEPTH = CW'(QUEUE_DEPTH);

  state_t                   state, state_next;
  cmd_t                     op_cmd;
  logic [ID_WIDTH-1:0]      op_id;
  logic [PAYLOAD_WIDTH-1:0] op_payload;
  logic [CW-1:0]            count, count_next;
  logic [CW-1:0]            urg;
  logic [CW-1:0]            ptr;
  logic [QUEUE_DEPTH-1:0]   hits;
  logic [QUEUE_DEPTH-1:0]   live;
  status_t                  res_status;
  status_t                  exec_status;
  logic                     out_free;
  logic                     do_push, do_pop;

  assign out_free     = !out_valid || out_ready;
  assign in_ready     = (state == S_IDLE);
  assign load_id      = op_id;
  assign load_payload = op_payload;

  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      live[k] = (CW'(k) < count);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (cmd_t'(cmd) == CMD_PROMOTE) ? S_SEARCH : S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) state_next = S_IDLE;
      end
      S_SEARCH: begin
        if (ptr >= count) state_next = S_REPORT;
        else if (hits[ptr[IW-1:0]]) state_next = S_BUBBLE;
      end
      S_BUBBLE: begin
        if (ptr <= urg) state_next = S_REPORT;
      end
      S_REPORT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Cell commands
  always_comb begin
    do_push   = (state == S_EXEC) && out_free && (op_cmd == CMD_PUSH) && (count < DEPTH);
    do_pop    = (state == S_EXEC) && out_free && (op_cmd == CMD_POP) && (count != '0);
    ctl.load  = do_push;
    ctl.shift = do_pop;
    ctl.swap  = (state == S_BUBBLE) && (ptr > urg);
    sel       = (state == S_BUBBLE) ? ptr : count;
  end

  always_comb begin
    exec_status = STAT_OK;
    count_next  = count;
    unique case (op_cmd)
      CMD_PUSH: begin
        if (count >= DEPTH) exec_status = STAT_FULL;
        else count_next = count + CW'(1);
      end
      CMD_POP: begin
        if (count == '0) exec_status = STAT_EMPTY;
        else count_next = count - CW'(1);
      end
      default: exec_status = STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      urg       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_EXEC || state == S_REPORT) && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_cmd     <= cmd_t'(cmd);
            op_id      <= flight_id;
            op_payload <= payload;
            ptr        <= '0;
            hits       <= cell_match & live;
            res_status <= STAT_OK;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            count          <= count_next;
            if (do_pop && urg != '0) urg <= urg - CW'(1);
            status         <= exec_status;
            popped_valid   <= do_pop;
            popped_id      <= do_pop ? head_id : '0;
            popped_payload <= do_pop ? head_payload : '0;
            occupancy      <= count_next;
          end
        end
        S_SEARCH: begin
          if (ptr >= count) res_status <= STAT_NOT_FOUND;
          else if (!hits[ptr[IW-1:0]]) ptr <= ptr + CW'(1);
        end
        S_BUBBLE: begin
          if (ptr > urg) ptr <= ptr - CW'(1);
          else if (ptr == urg) urg <= urg + CW'(1);
        end
        S_REPORT: begin
          if (out_free) begin
            status         <= res_status;
            popped_valid   <= 1'b0;
            popped_id      <= '0;
            popped_payload <= '0;
            occupancy      <= count;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[tb/tcq_checker.sv]
// Checker for the two-class queue: watches both channels, predicts each result and compares.
module tcq_checker #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [tcq_pkg::CMD_WIDTH-1:0]    cmd,
  input  logic [tcq_pkg::ID_WIDTH-1:0]     flight_id,
  input  logic [PAYLOAD_WIDTH-1:0]         payload,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [tcq_pkg::STATUS_WIDTH-1:0] status,
  input  logic                             popped_valid,
  input  logic [tcq_pkg::ID_WIDTH-1:0]     popped_id,
  input  logic [PAYLOAD_WIDTH-1:0]         popped_payload,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy,
  output int                               pending,
  output int                               fail_count,
  output int                               results_checked,
  output int                               promote_moves,
  output int                               full_pushes,
  output int                               empty_pops
);
  import tcq_pkg::*;

  localparam int OCC_W = $clog2(QUEUE_DEPTH+1);

  typedef struct packed {
    status_t                  status;
    logic                     pv;
    logic [ID_WIDTH-1:0]      pid;
    logic [PAYLOAD_WIDTH-1:0] ppay;
    logic [OCC_W-1:0]         occ;
  } queue_result_t;

  // Shadow copy of the queue, head at index 0.
  logic [ID_WIDTH-1:0]      shadow_ids [QUEUE_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] shadow_pay [QUEUE_DEPTH];
  logic                     shadow_urg [QUEUE_DEPTH];
  int                       shadow_count;

  queue_result_t expected_results[$];

  initial begin
    pending         = 0;
    fail_count      = 0;
    results_checked = 0;
    promote_moves   = 0;
    full_pushes     = 0;
    empty_pops      = 0;
    shadow_count    = 0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      shadow_ids[k] = '0;
      shadow_pay[k] = '0;
      shadow_urg[k] = 1'b0;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count < 20)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Apply one operation to the shadow queue and return the result it should give.
  task automatic apply_queue_op(input cmd_t c, input logic [ID_WIDTH-1:0] id,
                                input logic [PAYLOAD_WIDTH-1:0] pay,
                                output queue_result_t r);
    int                       hit;
    int                       dest;
    logic [ID_WIDTH-1:0]      sid;
    logic [PAYLOAD_WIDTH-1:0] spay;
    r        = '0;
    r.status = STAT_OK;
    case (c)
      CMD_PUSH: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
          full_pushes++;
        end else begin
          shadow_ids[shadow_count] = id;
          shadow_pay[shadow_count] = pay;
          shadow_urg[shadow_count] = 1'b0;
          shadow_count++;
        end
      end
      CMD_POP: begin
        if (shadow_count == 0) begin
          r.status = STAT_EMPTY;
          empty_pops++;
        end else begin
          r.pv   = 1'b1;
          r.pid  = shadow_ids[0];
          r.ppay = shadow_pay[0];
          for (int k = 1; k < shadow_count; k++) begin
            shadow_ids[k-1] = shadow_ids[k];
            shadow_pay[k-1] = shadow_pay[k];
            shadow_urg[k-1] = shadow_urg[k];
          end
          shadow_count--;
          shadow_urg[shadow_count] = 1'b0;
        end
      end
      CMD_PROMOTE: begin
        hit = shadow_count;
        for (int k = 0; k < shadow_count; k++)
          if (shadow_ids[k] == id) begin
            hit = k;
            break;
          end
        if (hit >= shadow_count) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          if (!shadow_urg[hit] && hit != 0) begin
            // Land just behind the urgent prefix.
            dest = hit;
            for (int k = 0; k < hit; k++)
              if (!shadow_urg[k]) begin
                dest = k;
                break;
              end
            sid  = shadow_ids[hit];
            spay = shadow_pay[hit];
            for (int k = hit; k > dest; k--) begin
              shadow_ids[k] = shadow_ids[k-1];
              shadow_pay[k] = shadow_pay[k-1];
              shadow_urg[k] = shadow_urg[k-1];
            end
            shadow_ids[dest] = sid;
            shadow_pay[dest] = spay;
            if (dest != hit) promote_moves++;
            hit = dest;
          end
          shadow_urg[hit] = 1'b1;
        end
      end
      default: ;
    endcase
    r.occ = OCC_W'(shadow_count);
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    queue_result_t fresh;
    if (!rst) begin
      // Check the outgoing transfer first; its expectation is always older.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, status", status, 0);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (status != want.status)
            report_mismatch("status", status, want.status);
          if (popped_valid != want.pv)
            report_mismatch("popped_valid", popped_valid, want.pv);
          if (popped_id != want.pid)
            report_mismatch("popped_id", popped_id, want.pid);
          if (popped_payload != want.ppay)
            report_mismatch("popped_payload", popped_payload, want.ppay);
          if (occupancy != want.occ)
            report_mismatch("occupancy", occupancy, want.occ);
        end
      end
      if (in_valid && in_ready) begin
        apply_queue_op(cmd_t'(cmd), flight_id, payload, fresh);
        expected_results.push_back(fresh);
      end
    end
    pending <= expected_results.size();
  end

endmodule

[tb/two_class_queue_with_promotion_unit_tb.sv]
// Testbench top for the two-class queue: stimulus, idling phases and the verdict.
module two_class_queue_with_promotion_unit_tb;
  import tcq_pkg::*;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int OCC_W         = $clog2(QUEUE_DEPTH+1);
  // Worst promote: scan the full chain and bubble back to the front, plus margin.
  localparam int DRAIN_CYCLES  = 2 + 2 * QUEUE_DEPTH + 8;
  localparam int PHASE_ITEMS   = 132;

  // Drive every input to a known value from time zero.
  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic [CMD_WIDTH-1:0]     cmd       = CMD_PUSH;
  logic [ID_WIDTH-1:0]      flight_id = '0;
  logic [PAYLOAD_WIDTH-1:0] payload   = '0;
  logic                     out_ready = 1'b0;

  logic                     in_ready;
  logic                     out_valid;
  logic [STATUS_WIDTH-1:0]  status;
  logic                     popped_valid;
  logic [ID_WIDTH-1:0]      popped_id;
  logic [PAYLOAD_WIDTH-1:0] popped_payload;
  logic [OCC_W-1:0]         occupancy;

  int pending;
  int fail_count;
  int results_checked;
  int promote_moves;
  int full_pushes;
  int empty_pops;

  // Idling odds out of a hundred, set per phase by the stimulus.
  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  int items_sent        = 0;

  always #1 clk = ~clk;

  two_class_queue_with_promotion_unit #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .flight_id     (flight_id),
    .payload       (payload),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .popped_valid  (popped_valid),
    .popped_id     (popped_id),
    .popped_payload(popped_payload),
    .occupancy     (occupancy)
  );

  tcq_checker #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .flight_id      (flight_id),
    .payload        (payload),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .popped_valid   (popped_valid),
    .popped_id      (popped_id),
    .popped_payload (popped_payload),
    .occupancy      (occupancy),
    .pending        (pending),
    .fail_count     (fail_count),
    .results_checked(results_checked),
    .promote_moves  (promote_moves),
    .full_pushes    (full_pushes),
    .empty_pops     (empty_pops)
  );

  // Receiver: decide ready afresh on each falling edge; one assignment per edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Hard stop in case the handshake locks up.
  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one item and hold it until the transfer. Enter and leave on a falling edge.
  task automatic send_item(input cmd_t c, input logic [ID_WIDTH-1:0] id,
                           input logic [PAYLOAD_WIDTH-1:0] pay);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    // Drop valid only when a gap follows; otherwise keep it high into the next item.
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd       <= c;
    flight_id <= id;
    payload   <= pay;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Mostly a small pool so that promotes hit and duplicates occur; sometimes the full range.
  function automatic logic [ID_WIDTH-1:0] pick_id();
    if ($urandom_range(99) < 80) return ID_WIDTH'($urandom_range(23));
    return ID_WIDTH'($urandom_range(9999));
  endfunction

  function automatic logic [PAYLOAD_WIDTH-1:0] pick_payload();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return '0;
    if (r < 10) return '1;
    return PAYLOAD_WIDTH'($urandom);
  endfunction

  // Pick an operation; filling stretches favour push, draining stretches favour pop.
  function automatic cmd_t pick_cmd(input bit filling);
    int r;
    r = $urandom_range(99);
    if (filling) begin
      if (r < 55) return CMD_PUSH;
      if (r < 75) return CMD_POP;
    end else begin
      if (r < 20) return CMD_PUSH;
      if (r < 70) return CMD_POP;
    end
    if (r < 97) return CMD_PROMOTE;
    return CMD_NONE;
  endfunction

  initial begin
    bit filling;
    cmd_t c;
    // Hold reset, then release it on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty queue cases first.
    send_item(CMD_POP, '0, '0);
    send_item(CMD_PROMOTE, 14'd5, '0);
    send_item(CMD_NONE, 14'd9999, '1);
    // Fill to the brim; extremes of id and payload up front, a duplicate of 103 in slot 6.
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      if (k == 0)      send_item(CMD_PUSH, 14'd0, '0);
      else if (k == 1) send_item(CMD_PUSH, 14'd9999, '1);
      else if (k == 6) send_item(CMD_PUSH, 14'd103, PAYLOAD_WIDTH'($urandom));
      else             send_item(CMD_PUSH, ID_WIDTH'(100 + k), PAYLOAD_WIDTH'($urandom));
    end
    send_item(CMD_PUSH, 14'd1234, PAYLOAD_WIDTH'($urandom));  // push when full
    send_item(CMD_PROMOTE, 14'd0, '0);      // head: mark only
    send_item(CMD_PROMOTE, 14'd115, '0);    // tail: bubble to behind the head
    send_item(CMD_PROMOTE, 14'd103, '0);    // duplicate: first match wins
    send_item(CMD_PROMOTE, 14'd103, '0);    // already urgent: no move
    send_item(CMD_PROMOTE, 14'd4242, '0);   // absent on a full queue
    send_item(CMD_POP, '0, '0);

    // Random phases: no idling, sender idle, receiver stalling, both lightly.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 77; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 77; end
        default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
      endcase
      filling = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Flip between filling and draining in stretches so occupancy sweeps end to end.
        if (n % 30 == 0 && n != 0) filling = 1'($urandom_range(1));
        c = pick_cmd(filling);
        send_item(c, pick_id(), pick_payload());
      end
    end

    // Lower valid, wait for every outstanding result, then let the block settle.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d items over four idling phases, checked %0d results.",
             items_sent, results_checked);
    $display("Promotes that moved an entry: %0d, pushes when full: %0d, pops when empty: %0d.",
             promote_moves, full_pushes, empty_pops);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[two_class_queue_with_promotion_unit.f]
src/tcq_pkg.sv
src/tcq_cell.sv
src/tcq_ctrl.sv
src/two_class_queue_with_promotion_unit.sv
tb/tcq_checker.sv
tb/two_class_queue_with_promotion_unit_tb.sv
